>>> rtl/ftd_pkg.sv
package ftd_pkg;

  // Binary bits folded into the decimal register per conversion cycle.
  localparam int unsigned BITS_PER_STEP = 4;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_DIGIT,
    SEL_POINT
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      step;
    logic      ptr_init;
    logic      ptr_dec;
    logic      out_load;
    logic      out_last;
    char_sel_e char_sel;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic conv_last;
    logic int_last;
    logic frac_present;
    logic frac_last;
  } stat_t;

endpackage

>>> rtl/ftd_in_if.sv
interface ftd_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/ftd_out_if.sv
interface ftd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

>>> rtl/ftd_datapath.sv
module ftd_datapath #(
  parameter int unsigned VALUE_WIDTH     = 32,
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  ftd_pkg::cmd_t                 cmd_i,
  output ftd_pkg::stat_t                stat_o,
  output logic [7:0]                    text_char_o,
  output logic                          last_o
);

  localparam int unsigned STEPS =
      (VALUE_WIDTH + ftd_pkg::BITS_PER_STEP - 1) / ftd_pkg::BITS_PER_STEP;
  localparam int unsigned PAD_W      = STEPS * ftd_pkg::BITS_PER_STEP;
  localparam int unsigned BIN_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned NUM_DIGITS =
      (BIN_DIGITS > FRACTION_DIGITS) ? BIN_DIGITS : FRACTION_DIGITS + 1;
  localparam int unsigned BCD_W = 4 * NUM_DIGITS;
  localparam int unsigned PTR_W = $clog2(NUM_DIGITS);
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [PAD_W-1:0]       mag_q;
  logic [PAD_W-1:0]       mag_step;
  logic [BCD_W-1:0]       bcd_q;
  logic [BCD_W-1:0]       bcd_step;
  logic [CNT_W-1:0]       cnt_q;
  logic [PTR_W-1:0]       ptr_q;
  logic [PTR_W-1:0]       int_top;
  logic [PTR_W-1:0]       frac_end;
  logic                   frac_any;
  logic                   neg_q;
  logic [3:0]             digit;
  logic [7:0]             char_d;
  logic [7:0]             char_q;
  logic                   last_q;

  assign raw    = $unsigned(value_i);
  assign mag_in = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

  // Shift-and-add-three conversion, several bits per cycle.
  always_comb begin
    bcd_step = bcd_q;
    mag_step = mag_q;
    for (int b = 0; b < int'(ftd_pkg::BITS_PER_STEP); b++) begin
      for (int d = 0; d < int'(NUM_DIGITS); d++) begin
        if (bcd_step[4*d +: 4] >= 4'd5) begin
          bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], mag_step[PAD_W-1]};
      mag_step = {mag_step[PAD_W-2:0], 1'b0};
    end
  end

  always_comb begin
    int_top  = PTR_W'(FRACTION_DIGITS);
    frac_end = '0;
    frac_any = 1'b0;
    for (int i = int'(FRACTION_DIGITS); i < int'(NUM_DIGITS); i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        int_top = PTR_W'(i);
      end
    end
    for (int i = int'(FRACTION_DIGITS) - 1; i >= 0; i--) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        frac_end = PTR_W'(i);
        frac_any = 1'b1;
      end
    end
  end

  assign digit = bcd_q[4*ptr_q +: 4];

  always_comb begin
    case (cmd_i.char_sel)
      ftd_pkg::SEL_MINUS: char_d = ftd_pkg::CHAR_MINUS;
      ftd_pkg::SEL_POINT: char_d = ftd_pkg::CHAR_POINT;
      ftd_pkg::SEL_DIGIT: char_d = ftd_pkg::CHAR_ZERO + {4'd0, digit};
      default:            char_d = ftd_pkg::CHAR_ZERO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.ptr_init) begin
        ptr_q <= int_top;
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= PAD_W'(mag_in);
      bcd_q <= '0;
      neg_q <= raw[VALUE_WIDTH-1];
    end else if (cmd_i.step) begin
      mag_q <= mag_step;
      bcd_q <= bcd_step;
    end
    if (cmd_i.out_load) begin
      char_q <= char_d;
      last_q <= cmd_i.out_last;
    end
  end

  assign stat_o.neg          = neg_q;
  assign stat_o.conv_last    = (cnt_q == CNT_W'(STEPS - 1));
  assign stat_o.int_last     = (ptr_q == PTR_W'(FRACTION_DIGITS));
  assign stat_o.frac_present = frac_any;
  assign stat_o.frac_last    = (ptr_q == frac_end);

  assign text_char_o = char_q;
  assign last_o      = last_q;

endmodule

>>> rtl/ftd_controller.sv
module ftd_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  ftd_pkg::stat_t stat_i,
  output ftd_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_PREP,
    S_SIGN,
    S_INT,
    S_POINT,
    S_FRAC
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.char_sel = ftd_pkg::SEL_DIGIT;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (stat_i.conv_last) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.ptr_init = 1'b1;
        state_d        = stat_i.neg ? S_SIGN : S_INT;
      end
      S_SIGN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.char_sel = ftd_pkg::SEL_MINUS;
          state_d        = S_INT;
        end
      end
      S_INT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.ptr_dec  = 1'b1;
          cmd_o.out_last = stat_i.int_last && !stat_i.frac_present;
          if (stat_i.int_last) begin
            state_d = stat_i.frac_present ? S_POINT : S_IDLE;
          end
        end
      end
      S_POINT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.char_sel = ftd_pkg::SEL_POINT;
          state_d        = S_FRAC;
        end
      end
      S_FRAC: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.ptr_dec  = 1'b1;
          cmd_o.out_last = stat_i.frac_last;
          if (stat_i.frac_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A held beat is never overwritten before the receiver has taken it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while stalled");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CONV))
    else $error("accepted value did not start conversion");

  a_prep_to_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP) |=> (state_q == S_SIGN || state_q == S_INT))
    else $error("text did not start after conversion");

  a_last_from_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |-> (cmd_o.char_sel == ftd_pkg::SEL_DIGIT))
    else $error("final beat is not a digit");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> (state_q == S_IDLE))
    else $error("final beat did not end the value");

endmodule

>>> rtl/fixed_point_to_decimal_text_top.sv
// Converts signed fixed-point values (value / 10^FRACTION_DIGITS) to ASCII text.
// The input channel in_i carries one value per beat; the output channel out_o
// carries one character per beat, with last set on the final character.
// Text is an optional minus sign, the integer part without leading zeros,
// and, for a non-zero fraction, a point and the fraction digits without
// trailing zeros. The most negative value uses its full magnitude.
// After a value is accepted, the binary-to-decimal unit folds four bits per
// cycle into a decimal register, followed by a set-up step that points at the
// leading digit. Characters then leave one per cycle through an output
// register while the receiver keeps taking them. One value is handled at a
// time, and the next value may be accepted while the final character of the
// previous one still waits in the output register.
// When the receiver stalls, the pending character is held and conversion of
// further characters pauses. Reset empties the output register and returns
// the block to accepting input.
module fixed_point_to_decimal_text_top #(
  parameter int unsigned VALUE_WIDTH     = 32,
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ftd_in_if.sink           in_i,
  ftd_out_if.source        out_o
);

  ftd_pkg::cmd_t  cmd;
  ftd_pkg::stat_t stat;

  ftd_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ftd_datapath #(
    .VALUE_WIDTH     (VALUE_WIDTH),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .text_char_o (out_o.text_char),
    .last_o      (out_o.last)
  );

endmodule
